// ===== hdl/grid_neighbor_expander_defines.svh =====
// assertion macros for the grid neighbor expander
`ifndef GRID_NEIGHBOR_EXPANDER_DEFINES_SVH
`define GRID_NEIGHBOR_EXPANDER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define GNE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define GNE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gne_pkg.sv =====
// types, codes and divider step for the grid neighbor expander
`timescale 1ns / 1ps

package gne_pkg;

    localparam int ID_W       = 14;
    localparam int DIM_W      = 8;
    localparam int DIR_W      = 2;
    localparam int NUM_DIRS   = 4;
    localparam int NID_W      = ID_W + 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 4;
    localparam int QUO_W      = DIV_BITS * DIV_STAGES;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_EXPAND = 1'b1;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd1;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] cell_id;
        logic            blocked;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  neighbor_id;
        logic [DIR_W-1:0] direction;
        logic             neighbor_valid;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  id;
        logic             blocked;
        logic [DIM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]    rem;
        logic [DIV_BITS-1:0] quo;
    } div_res_t;

    // restoring division, DIV_BITS quotient bits per call
    function automatic div_res_t div_step(input logic [DIM_W-1:0]    rem_in,
                                          input logic [DIV_BITS-1:0] bits,
                                          input logic [DIM_W-1:0]    divisor);
        div_res_t       res;
        logic [DIM_W:0] part;
        res.rem = rem_in;
        res.quo = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            part = {res.rem, bits[i]};
            if (part >= {1'b0, divisor})
            begin
                part       = part - {1'b0, divisor};
                res.quo[i] = 1'b1;
            end
            res.rem = part[DIM_W-1:0];
        end
        return res;
    endfunction

    // zero counts as one, anything above the limit counts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        else if (v > lim)
            r = lim;
        return r;
    endfunction

endpackage

// ===== hdl/grid_neighbor_expander.sv =====
// top level of the grid neighbor expander: divider pipeline, map lookup, result serializer
`timescale 1ns / 1ps
//
// usage
//   in channel : in_valid / in_stall / in_item. an item is taken at a clock edge with
//                in_valid high and in_stall low. func write stores one obstacle bit and
//                gives no result; func expand gives one to four results.
//   out channel: out_valid / out_stall / out_item, same rule; the sink drives out_stall.
//   cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 grid_cols,
//                index 1 grid_rows. write only while the block is idle.
// path: the first result of an expand reaches the output register through 4 divider
//   stages, the neighbor stage, the map read and the serializer.
// throughput: one item can enter every cycle while the pipeline advances. the serializer
//   emits one result a cycle while the output is free, and holds an expand until all its
//   results (1 to 4) are out; writes never enter it. the output port is the bottleneck.
// reset: the map is cleared by a pass over all MAX_ROWS*MAX_COLS cells (capped at
//   16384), one cell a cycle; in_stall stays high until it is done. config writes are
//   taken during that pass.
// stall: when out_stall holds the output register, the pipeline freezes once an expand
//   reaches the map stage while the serializer is busy; nothing is lost or repeated.

`include "grid_neighbor_expander_defines.svh"

module grid_neighbor_expander
    import gne_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // item input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    // result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    // map geometry; cell ids are only 14 bits wide, so storage never exceeds 2**ID_W
    localparam int MAP_CELLS = MAX_ROWS * MAX_COLS;
    localparam int MAP_DEPTH = (MAP_CELLS < (2 ** ID_W)) ? MAP_CELLS : (2 ** ID_W);
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam logic [31:0] MAP_CELLS_U = 32'(MAP_CELLS);
    localparam logic [31:0] MAP_DEPTH_U = 32'(MAP_DEPTH);
    localparam int DIM_MAX   = (2 ** DIM_W) - 1;
    localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'((MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS);
    localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'((MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS);

    // ------------------------------------------------------------------
    // configuration, stored already clamped
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] cols_reg, cols_next;
    logic [DIM_W-1:0] rows_reg, rows_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_COLS: cols_next = clamp_dim(cfg_data, COLS_LIM);
                CFG_GRID_ROWS: rows_next = clamp_dim(cfg_data, ROWS_LIM);
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= clamp_dim(DIM_RESET, COLS_LIM);
            rows_reg <= clamp_dim(DIM_RESET, ROWS_LIM);
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    // ------------------------------------------------------------------
    // map clearing pass after reset
    // ------------------------------------------------------------------
    logic              clr_active_reg;
    logic [MAP_AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + MAP_AW'(1);
            if (clr_addr_reg == MAP_AW'(MAP_DEPTH - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // global advance of the divider, neighbor and map stages
    logic adv;

    assign in_stall = clr_active_reg || !adv;

    // ------------------------------------------------------------------
    // divider stages: row = id / cols, col = id % cols, DIV_BITS bits per stage
    // ------------------------------------------------------------------
    div_item_t div_reg        [DIV_STAGES];
    div_item_t div_next       [DIV_STAGES];
    logic      div_valid_reg  [DIV_STAGES];
    logic      div_valid_next [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        div_item_t        src;
        div_res_t         step;
        logic [QUO_W-1:0] dividend;

        if (k == 0)
        begin : g_first
            assign src = '{func: in_item.func, id: in_item.cell_id,
                           blocked: in_item.blocked, rem: '0, quo: '0};
            assign div_valid_next[k] = in_valid && !clr_active_reg;
        end
        else
        begin : g_rest
            assign src = div_reg[k-1];
            assign div_valid_next[k] = div_valid_reg[k-1];
        end

        assign dividend = QUO_W'(src.id);
        assign step     = div_step(src.rem, dividend[QUO_W-1-DIV_BITS*k -: DIV_BITS],
                                   cols_reg);
        assign div_next[k] = '{func: src.func, id: src.id, blocked: src.blocked,
                               rem: step.rem,
                               quo: {src.quo[QUO_W-DIV_BITS-1:0], step.quo}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                div_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                div_valid_reg[k] <= div_valid_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                div_reg[k] <= div_next[k];
        end
    end

    // ------------------------------------------------------------------
    // neighbor stage: the four candidate ids follow from id +/- cols and id +/- 1
    // ------------------------------------------------------------------
    div_item_t         dv;
    logic [ID_W-1:0]   dv_row;
    logic              dv_in_rows;
    logic [NID_W-1:0]  id_ext;
    logic [NID_W-1:0]  cols_ext;
    logic [NID_W-1:0]  nid_next   [NUM_DIRS];
    logic [NUM_DIRS-1:0] inb_next;
    logic [NUM_DIRS-1:0] ok_next;
    logic [NUM_DIRS-1:0] inmem_next;

    assign dv       = div_reg[DIV_STAGES-1];
    assign dv_row   = dv.quo[ID_W-1:0];
    assign id_ext   = NID_W'(dv.id);
    assign cols_ext = NID_W'(cols_reg);

    // a vertex below the last row keeps only the up move, and only from the row just below
    assign dv_in_rows = (NID_W'(dv_row) < NID_W'(rows_reg));

    always_comb
    begin
        nid_next[DIR_UP]    = id_ext - cols_ext;
        nid_next[DIR_DOWN]  = id_ext + cols_ext;
        nid_next[DIR_RIGHT] = id_ext + NID_W'(1);
        nid_next[DIR_LEFT]  = id_ext - NID_W'(1);

        inb_next[DIR_UP]    = (dv_row != '0) && (NID_W'(dv_row) <= NID_W'(rows_reg));
        inb_next[DIR_DOWN]  = ((NID_W'(dv_row) + NID_W'(1)) < NID_W'(rows_reg));
        inb_next[DIR_RIGHT] = dv_in_rows && (({1'b0, dv.rem} + 9'(1)) < {1'b0, cols_reg});
        inb_next[DIR_LEFT]  = dv_in_rows && (dv.rem != '0);

        for (int d = 0; d < NUM_DIRS; d++)
        begin
            // ids past the map count as blocked, ids past storage read as free
            ok_next[d]    = inb_next[d] && (32'(nid_next[d]) < MAP_CELLS_U);
            inmem_next[d] = (32'(nid_next[d]) < MAP_DEPTH_U);
        end
    end

    logic                nb_valid_reg;
    logic                nb_func_reg;
    logic [ID_W-1:0]     nb_id_reg;
    logic                nb_blocked_reg;
    logic [NID_W-1:0]    nb_nid_reg [NUM_DIRS];
    logic [NUM_DIRS-1:0] nb_ok_reg;
    logic [NUM_DIRS-1:0] nb_inmem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nb_valid_reg <= 1'b0;
        else if (adv)
            nb_valid_reg <= div_valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nb_func_reg    <= dv.func;
            nb_id_reg      <= dv.id;
            nb_blocked_reg <= dv.blocked;
            nb_nid_reg     <= nid_next;
            nb_ok_reg      <= ok_next;
            nb_inmem_reg   <= inmem_next;
        end
    end

    // ------------------------------------------------------------------
    // obstacle map: one copy per direction so all four lookups run in the same cycle.
    // writes hit every copy at the same stage where expands read, so order holds
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [MAP_AW-1:0]   ram_waddr;
    logic                ram_wdata;
    logic [NUM_DIRS-1:0] ram_q;

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = adv && nb_valid_reg && (nb_func_reg == FUNC_WRITE)
                        && (32'(nb_id_reg) < MAP_DEPTH_U);
            ram_waddr = nb_id_reg[MAP_AW-1:0];
            ram_wdata = nb_blocked_reg;
        end
    end

    for (genvar g = 0; g < NUM_DIRS; g++)
    begin : g_map
        gne_ram #(
            .WIDTH (1),
            .DEPTH (MAP_DEPTH)
        ) u_map (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (adv),
            .raddr (nb_nid_reg[g][MAP_AW-1:0]),
            .rdata (ram_q[g])
        );
    end

    // ------------------------------------------------------------------
    // map stage: lookup data arrives with the item
    // ------------------------------------------------------------------
    logic                mb_valid_reg;
    logic                mb_func_reg;
    logic [NID_W-1:0]    mb_nid_reg [NUM_DIRS];
    logic [NUM_DIRS-1:0] mb_ok_reg;
    logic [NUM_DIRS-1:0] mb_inmem_reg;
    logic [NUM_DIRS-1:0] mb_free;
    logic                mb_expand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mb_valid_reg <= 1'b0;
        else if (adv)
            mb_valid_reg <= nb_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mb_func_reg  <= nb_func_reg;
            mb_nid_reg   <= nb_nid_reg;
            mb_ok_reg    <= nb_ok_reg;
            mb_inmem_reg <= nb_inmem_reg;
        end
    end

    assign mb_free   = mb_ok_reg & ~(mb_inmem_reg & ram_q);
    assign mb_expand = mb_valid_reg && (mb_func_reg == FUNC_EXPAND);

    // ------------------------------------------------------------------
    // serializer: one result per cycle while the output is free, up first, left last
    // ------------------------------------------------------------------
    logic                sr_valid_reg;
    logic [NUM_DIRS-1:0] sr_mask_reg;
    logic [ID_W-1:0]     sr_nid_reg [NUM_DIRS];
    logic [NUM_DIRS-1:0] sr_pick_1h;
    logic [NUM_DIRS-1:0] sr_rest;
    logic [DIR_W-1:0]    sr_pick;
    logic                sr_empty;
    logic                sr_done;
    logic                sr_can_load;
    out_item_t           sr_item;

    logic                out_valid_reg;
    out_item_t           out_item_reg;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sr_pick = DIR_UP;
        for (int d = NUM_DIRS - 1; d >= 0; d--)
        begin
            if (sr_mask_reg[d])
                sr_pick = DIR_W'(d);
        end
    end

    assign sr_pick_1h  = sr_mask_reg & (~sr_mask_reg + NUM_DIRS'(1));
    assign sr_rest     = sr_mask_reg & ~sr_pick_1h;
    assign sr_empty    = (sr_mask_reg == '0);
    assign sr_done     = sr_valid_reg && out_free && (sr_empty || (sr_rest == '0));
    assign sr_can_load = !sr_valid_reg || sr_done;

    // the pipeline only waits when an expand reaches a busy serializer
    assign adv = !mb_expand || sr_can_load;

    always_comb
    begin
        if (sr_empty)
            sr_item = '{neighbor_id: '0, direction: DIR_UP, neighbor_valid: 1'b0,
                        last: 1'b1};
        else
            sr_item = '{neighbor_id: sr_nid_reg[sr_pick], direction: sr_pick,
                        neighbor_valid: 1'b1, last: (sr_rest == '0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sr_valid_reg <= 1'b0;
        else if (adv && mb_expand)
            sr_valid_reg <= 1'b1;
        else if (sr_done)
            sr_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && mb_expand)
        begin
            sr_mask_reg <= mb_free;
            for (int d = 0; d < NUM_DIRS; d++)
                sr_nid_reg[d] <= mb_nid_reg[d][ID_W-1:0];
        end
        else if (sr_valid_reg && out_free)
        begin
            sr_mask_reg <= sr_rest;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= sr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_item_reg <= sr_item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `GNE_ASSERT_NEXT(a_burst_gapless,
        out_valid_reg && !out_stall && !out_item_reg.last,
        out_valid_reg,
        "result burst has a gap before its last item")

    `GNE_ASSERT_NEXT(a_dir_order,
        out_valid_reg && !out_stall && !out_item_reg.last,
        out_item_reg.direction > $past(out_item_reg.direction),
        "directions within one expand not strictly rising")

    `GNE_ASSERT_NOW(a_clear_empty,
        clr_active_reg,
        !div_valid_reg[0] && !nb_valid_reg && !mb_valid_reg && !sr_valid_reg,
        "item in flight while the map is being cleared")

endmodule

// ===== hdl/gne_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module gne_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/grid_neighbor_expander_tb.sv =====
// self-checking testbench for the grid neighbor expander
`timescale 1ns / 1ps

module grid_neighbor_expander_tb
    import gne_pkg::*;
();

    // grid limits of the instance under test
    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 128;
    localparam int MAP_CELLS = MAX_ROWS * MAX_COLS;

    // writes leave no result behind, so after the last owed result this many quiet cycles
    // let the pipeline empty before a register write or the end
    localparam int DRAIN_CYCLES   = 16;
    // reset clears the map one cell a cycle with in_stall high, so the no-progress
    // limit sits well above the length of that pass
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 50;

    // move order and offsets of a four-connected expand
    localparam logic [DIR_W-1:0] MOVE_DIR [NUM_DIRS] = '{DIR_UP, DIR_DOWN, DIR_RIGHT, DIR_LEFT};
    localparam int               MOVE_DY  [NUM_DIRS] = '{-1, 1, 0, 0};
    localparam int               MOVE_DX  [NUM_DIRS] = '{0, 0, 1, -1};

    // the lone result of an expand that finds every move closed
    localparam out_item_t NO_NEIGHBOR = '{neighbor_id: '0, direction: DIR_UP,
                                          neighbor_valid: 1'b0, last: 1'b1};

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    // one line of the directed table: an item or a register write, with the
    // results typed in where they are obvious (typed_n of zero means predict)
    typedef struct {
        row_kind_t             kind;
        in_item_t              item;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [DIM_W-1:0]      cfg_val;
        int                    typed_n;
        out_item_t [3:0]       typed;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    // shadow copy of the block's state
    logic                 obstacle_bits [MAP_CELLS];
    logic [DIM_W-1:0]     cols_reg = DIM_RESET;
    logic [DIM_W-1:0]     rows_reg = DIM_RESET;

    // neighbors still owed by the block, oldest first
    out_item_t            expected_neighbors [$];
    dir_row_t             dir_table [$];

    int                   in_idle_pct  = 0;
    int                   out_idle_pct = 0;
    int                   fail_count   = 0;
    int                   idle_cycles  = 0;

    grid_neighbor_expander #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // reset asserted at the start and released once
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        foreach (obstacle_bits[i])
            obstacle_bits[i] = 1'b0;
    end

    // append one row to the directed table
    task automatic add_row(input dir_row_t row);
        dir_table.insert(dir_table.size(), row);
    endtask

    // queue one owed result behind the others
    task automatic owe_result(input out_item_t r);
        expected_neighbors.insert(expected_neighbors.size(), r);
    endtask

    // register value as the block sees it: zero means one, above the limit means the limit
    function automatic int grid_extent(input logic [DIM_W-1:0] v, input int lim);
        int r;
        r = int'(v);
        if (r == 0)
            r = 1;
        else if (r > lim)
            r = lim;
        return r;
    endfunction

    // apply one item to the shadow state; expands queue their neighbors
    task automatic predict_neighbors(input in_item_t it);
        int        cols;
        int        rows;
        int        row;
        int        col;
        int        ny;
        int        nx;
        int        nid;
        int        d;
        out_item_t found [$];
        out_item_t r;
        if (it.func == FUNC_WRITE)
        begin
            // every 14-bit id lies inside the map at these limits
            obstacle_bits[it.cell_id] = it.blocked;
            return;
        end
        cols = grid_extent(cols_reg, MAX_COLS);
        rows = grid_extent(rows_reg, MAX_ROWS);
        // a vertex below the last row is still split; only in-border moves survive
        row = int'(it.cell_id) / cols;
        col = int'(it.cell_id) % cols;
        for (d = 0; d < NUM_DIRS; d++)
        begin
            ny = row + MOVE_DY[d];
            nx = col + MOVE_DX[d];
            if (ny < 0 || ny >= rows || nx < 0 || nx >= cols)
                continue;
            nid = ny * cols + nx;
            // the vertex's own blocked bit plays no part, only the neighbor's
            if (nid >= MAP_CELLS || obstacle_bits[nid])
                continue;
            r.neighbor_id    = nid[ID_W-1:0];
            r.direction      = MOVE_DIR[d];
            r.neighbor_valid = 1'b1;
            r.last           = 1'b0;
            found.insert(found.size(), r);
        end
        if (found.size() == 0)
            found.insert(0, NO_NEIGHBOR);
        else
            found[found.size()-1].last = 1'b1;
        foreach (found[i])
            owe_result(found[i]);
    endtask

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input in_item_t it);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // one register write; the next send_item or drain lowers cfg_valid
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_GRID_COLS)
            cols_reg = val;
        else
            rows_reg = val;
    endtask

    // stop offering, wait for every owed neighbor, then let trailing writes settle
    task automatic drain_pipeline();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_neighbors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly cells inside the grid in use (and a row past it), some anywhere in 14 bits
    function automatic in_item_t random_item();
        in_item_t it;
        int       span;
        span = grid_extent(cols_reg, MAX_COLS) * (grid_extent(rows_reg, MAX_ROWS) + 1);
        if (span > MAP_CELLS)
            span = MAP_CELLS;
        it.func    = ($urandom_range(99) < 40) ? FUNC_WRITE : FUNC_EXPAND;
        it.blocked = ($urandom_range(99) < 35);
        if ($urandom_range(9) == 0)
            it.cell_id = ID_W'($urandom_range(MAP_CELLS - 1));
        else
            it.cell_id = ID_W'($urandom_range(span - 1));
        return it;
    endfunction

    function automatic out_item_t hit(input int id, input logic [DIR_W-1:0] dir,
                                      input logic is_last);
        out_item_t r;
        r.neighbor_id    = id[ID_W-1:0];
        r.direction      = dir;
        r.neighbor_valid = 1'b1;
        r.last           = is_last;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic func, input int id, input logic blk,
                                          input int n = 0,
                                          input out_item_t r0 = '0, input out_item_t r1 = '0,
                                          input out_item_t r2 = '0, input out_item_t r3 = '0);
        dir_row_t row;
        row.kind         = ROW_ITEM;
        row.item.func    = func;
        row.item.cell_id = id[ID_W-1:0];
        row.item.blocked = blk;
        row.cfg_idx      = '0;
        row.cfg_val      = '0;
        row.typed_n      = n;
        row.typed        = {r3, r2, r1, r0};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] val);
        dir_row_t row;
        row         = item_row(FUNC_WRITE, 0, 1'b0);
        row.kind    = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    // result side: take, compare with the oldest owed neighbor, then pick the next stall
    initial
    begin : result_check
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_neighbors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item: id %0d dir %0d valid %0b last %0b",
                                 out_item.neighbor_id, out_item.direction,
                                 out_item.neighbor_valid, out_item.last);
                end
                else
                begin
                    want = expected_neighbors.pop_front();
                    if (want.neighbor_id !== out_item.neighbor_id ||
                        want.direction !== out_item.direction ||
                        want.neighbor_valid !== out_item.neighbor_valid ||
                        want.last !== out_item.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("mismatch: expected id %0d dir %0d valid %0b last %0b",
                                   want.neighbor_id, want.direction, want.neighbor_valid,
                                   want.last);
                            $display(", got id %0d dir %0d valid %0b last %0b",
                                     out_item.neighbor_id, out_item.direction,
                                     out_item.neighbor_valid, out_item.last);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // no handshake on any channel for too long ends the run
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int        phase_cols [RANDOM_PHASES] = '{8, 0, 255, 128, 13, 1, 3, 37, 128};
        int        phase_rows [RANDOM_PHASES] = '{8, 5, 1, 128, 7, 1, 200, 128, 2};
        in_item_t  it;

        // directed rows, reset geometry 128 x 128 and an empty map to start
        // corners and an inner cell with every move open
        add_row(item_row(FUNC_EXPAND, 0, 1'b0, 2,
                         hit(128, DIR_DOWN, 1'b0), hit(1, DIR_RIGHT, 1'b1)));
        add_row(item_row(FUNC_EXPAND, 16383, 1'b0, 2,
                         hit(16255, DIR_UP, 1'b0), hit(16382, DIR_LEFT, 1'b1)));
        add_row(item_row(FUNC_EXPAND, 129, 1'b0, 4,
                         hit(1, DIR_UP, 1'b0), hit(257, DIR_DOWN, 1'b0),
                         hit(130, DIR_RIGHT, 1'b0), hit(128, DIR_LEFT, 1'b1)));
        // wall in the corner: no free neighbor left
        add_row(item_row(FUNC_WRITE, 1, 1'b1));
        add_row(item_row(FUNC_WRITE, 128, 1'b1));
        add_row(item_row(FUNC_EXPAND, 0, 1'b0, 1, NO_NEIGHBOR));
        // blocked vertex still expands
        add_row(item_row(FUNC_WRITE, 16383, 1'b1));
        add_row(item_row(FUNC_EXPAND, 16383, 1'b1, 2,
                         hit(16255, DIR_UP, 1'b0), hit(16382, DIR_LEFT, 1'b1)));
        // reopen a cell
        add_row(item_row(FUNC_WRITE, 1, 1'b0));
        add_row(item_row(FUNC_EXPAND, 0, 1'b0, 1, hit(1, DIR_RIGHT, 1'b1)));
        add_row(item_row(FUNC_EXPAND, 129, 1'b1));
        // zero columns act as one, rows above the limit act as the limit
        add_row(cfg_row(CFG_GRID_COLS, 8'd0));
        add_row(cfg_row(CFG_GRID_ROWS, 8'd255));
        add_row(item_row(FUNC_EXPAND, 5, 1'b0, 2,
                         hit(4, DIR_UP, 1'b0), hit(6, DIR_DOWN, 1'b1)));
        // vertices below the last row
        add_row(item_row(FUNC_EXPAND, 200, 1'b0, 1, NO_NEIGHBOR));
        add_row(item_row(FUNC_EXPAND, 128, 1'b0, 1, hit(127, DIR_UP, 1'b1)));
        // single row, columns above the limit
        add_row(cfg_row(CFG_GRID_COLS, 8'd255));
        add_row(cfg_row(CFG_GRID_ROWS, 8'd1));
        add_row(item_row(FUNC_EXPAND, 5, 1'b0, 2,
                         hit(6, DIR_RIGHT, 1'b0), hit(4, DIR_LEFT, 1'b1)));
        // odd width: stored bits are read under the new layout
        add_row(cfg_row(CFG_GRID_COLS, 8'd7));
        add_row(cfg_row(CFG_GRID_ROWS, 8'd3));
        add_row(item_row(FUNC_WRITE, 13, 1'b1));
        add_row(item_row(FUNC_EXPAND, 20, 1'b0));
        add_row(item_row(FUNC_EXPAND, 21, 1'b0));
        add_row(item_row(FUNC_EXPAND, 16383, 1'b1));
        add_row(item_row(FUNC_WRITE, 16383, 1'b0));

        wait (rst_n === 1'b1);
        @(posedge clk);

        in_idle_pct  = 15;
        out_idle_pct = 83;
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                drain_pipeline();
                write_reg(dir_table[i].cfg_idx, dir_table[i].cfg_val);
            end
            else
            begin
                send_item(dir_table[i].item);
                if (dir_table[i].typed_n == 0)
                    predict_neighbors(dir_table[i].item);
                else
                    for (int k = 0; k < dir_table[i].typed_n; k++)
                        owe_result(dir_table[i].typed[k]);
            end
        end

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_pipeline();
            write_reg(CFG_GRID_COLS, phase_cols[p][DIM_W-1:0]);
            write_reg(CFG_GRID_ROWS, phase_rows[p][DIM_W-1:0]);
            if (p < 3)
            begin
                in_idle_pct  = 15;
                out_idle_pct = 83;
            end
            else if (p < 6)
            begin
                in_idle_pct  = 83;
                out_idle_pct = 15;
            end
            else
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = random_item();
                send_item(it);
                predict_neighbors(it);
            end
        end

        drain_pipeline();
        if (fail_count == 0 && expected_neighbors.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gne_pkg.sv
hdl/gne_ram.sv
hdl/grid_neighbor_expander.sv
tb/sv/grid_neighbor_expander_tb.sv
